[src/xlseed_pkg.sv]
// Shared types, constants, command codes and functions for the xoshiro128++ lane seeder.
package xlseed_pkg;

  // Field widths.
  localparam int LANE_IDX_W = 10;
  localparam int COUNT_W    = 11;
  localparam int SEED_W     = 64;
  localparam int WORD_W     = 32;
  localparam int STEP_W     = 7;
  localparam int PHASE_W    = 4;

  // Largest lane count that a 10-bit lane index can address.
  localparam int INDEX_LANES = 1 << LANE_IDX_W;

  // Default for the lane limit parameter.
  localparam int DEF_MAX_LANES = 1024;

  // Configuration register indexes.
  localparam logic REG_SEED       = 1'b0;
  localparam logic REG_LANE_COUNT = 1'b1;

  // Splitmix64 constants.
  localparam logic [SEED_W-1:0] SM_GAMMA = 64'h9e3779b97f4a7c15;
  localparam logic [SEED_W-1:0] SM_MUL1  = 64'hbf58476d1ce4e5b9;
  localparam logic [SEED_W-1:0] SM_MUL2  = 64'h94d049bb133111eb;

  // Jump polynomial for the 2^64 jump, bit k applies at step k.
  localparam logic [127:0] JUMP_POLY = {32'h77f2db5b, 32'h6fa035c3,
                                        32'hf542d2d3, 32'h8764000b};
  localparam logic [STEP_W-1:0] STEP_LAST = 7'd127;

  // Splitmix round phases.
  localparam logic [PHASE_W-1:0] PH_XS30  = 4'd0;
  localparam logic [PHASE_W-1:0] PH_M1_0  = 4'd1;
  localparam logic [PHASE_W-1:0] PH_M1_1  = 4'd2;
  localparam logic [PHASE_W-1:0] PH_M1_2  = 4'd3;
  localparam logic [PHASE_W-1:0] PH_M1_3  = 4'd4;
  localparam logic [PHASE_W-1:0] PH_XS27  = 4'd5;
  localparam logic [PHASE_W-1:0] PH_M2_0  = 4'd6;
  localparam logic [PHASE_W-1:0] PH_M2_1  = 4'd7;
  localparam logic [PHASE_W-1:0] PH_M2_2  = 4'd8;
  localparam logic [PHASE_W-1:0] PH_M2_3  = 4'd9;
  localparam logic [PHASE_W-1:0] PH_FIN   = 4'd10;

  // Datapath operation codes.
  localparam logic [3:0] OP_NOP   = 4'd0;
  localparam logic [3:0] OP_LOAD  = 4'd1;
  localparam logic [3:0] OP_XS30  = 4'd2;
  localparam logic [3:0] OP_XS27  = 4'd3;
  localparam logic [3:0] OP_MUL0  = 4'd4;
  localparam logic [3:0] OP_MUL1  = 4'd5;
  localparam logic [3:0] OP_MUL2  = 4'd6;
  localparam logic [3:0] OP_MUL3  = 4'd7;
  localparam logic [3:0] OP_FIN   = 4'd8;
  localparam logic [3:0] OP_JCLR  = 4'd9;
  localparam logic [3:0] OP_JSTEP = 4'd10;
  localparam logic [3:0] OP_JEND  = 4'd11;
  localparam logic [3:0] OP_PUSH  = 4'd12;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic [3:0]        op;
    logic              csel;   // 0: first multiplier constant, 1: second
    logic [1:0]        widx;   // state word written at the end of a round
    logic [STEP_W-1:0] step;   // jump step number
  } xlseed_cmd_t;

  typedef logic [WORD_W-1:0] word_t;

  // One xoshiro128 state step on four words packed {s3, s2, s1, s0}.
  function automatic logic [4*WORD_W-1:0] xo_advance(input logic [4*WORD_W-1:0] s);
    logic [WORD_W-1:0] s0, s1, s2, s3, t;
    s0 = s[WORD_W-1:0];
    s1 = s[2*WORD_W-1:WORD_W];
    s2 = s[3*WORD_W-1:2*WORD_W];
    s3 = s[4*WORD_W-1:3*WORD_W];
    t  = s1 << 9;
    s2 = s2 ^ s0;
    s3 = s3 ^ s1;
    s1 = s1 ^ s2;
    s0 = s0 ^ s3;
    s2 = s2 ^ t;
    s3 = {s3[WORD_W-12:0], s3[WORD_W-1:WORD_W-11]};
    return {s3, s2, s1, s0};
  endfunction

endpackage

[src/xlseed_ctrl.sv]
// Controller state machine that sequences the seeding and jump work.
module xlseed_ctrl
  import xlseed_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic        restart,
  output logic        lane_valid,
  input  logic        lane_ready,
  input  logic        need_seed,
  output xlseed_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_SEED = 3'd2;
  localparam logic [2:0] S_JCLR = 3'd3;
  localparam logic [2:0] S_JUMP = 3'd4;
  localparam logic [2:0] S_JEND = 3'd5;
  localparam logic [2:0] S_PUSH = 3'd6;

  logic [2:0]         state, state_next;
  logic [PHASE_W-1:0] phase, phase_next;
  logic [1:0]         round, round_next;
  logic [STEP_W-1:0]  step, step_next;
  logic               lane_valid_next;

  assign req_ready = (state == S_IDLE) && !rst;

  // Next state and command decode.
  always_comb begin
    state_next      = state;
    phase_next      = phase;
    round_next      = round;
    step_next       = step;
    lane_valid_next = lane_ready ? 1'b0 : lane_valid;
    cmd.op          = OP_NOP;
    cmd.csel        = (phase >= PH_M2_0);
    cmd.widx        = round;
    cmd.step        = step;
    case (state)
      S_IDLE: begin
        if (req_valid && req_ready) begin
          state_next = (restart || need_seed) ? S_LOAD : S_JCLR;
        end
      end
      S_LOAD: begin
        cmd.op     = OP_LOAD;
        phase_next = PH_XS30;
        round_next = 2'd0;
        state_next = S_SEED;
      end
      S_SEED: begin
        case (phase)
          PH_XS30: cmd.op = OP_XS30;
          PH_M1_0: cmd.op = OP_MUL0;
          PH_M1_1: cmd.op = OP_MUL1;
          PH_M1_2: cmd.op = OP_MUL2;
          PH_M1_3: cmd.op = OP_MUL3;
          PH_XS27: cmd.op = OP_XS27;
          PH_M2_0: cmd.op = OP_MUL0;
          PH_M2_1: cmd.op = OP_MUL1;
          PH_M2_2: cmd.op = OP_MUL2;
          PH_M2_3: cmd.op = OP_MUL3;
          PH_FIN:  cmd.op = OP_FIN;
          default: cmd.op = OP_NOP;
        endcase
        if (phase == PH_FIN) begin
          phase_next = PH_XS30;
          round_next = round + 2'd1;
          if (round == 2'd3) begin
            state_next = S_PUSH;
          end
        end else begin
          phase_next = phase + 4'd1;
        end
      end
      S_JCLR: begin
        cmd.op     = OP_JCLR;
        step_next  = '0;
        state_next = S_JUMP;
      end
      S_JUMP: begin
        cmd.op    = OP_JSTEP;
        step_next = step + 7'd1;
        if (step == STEP_LAST) begin
          state_next = S_JEND;
        end
      end
      S_JEND: begin
        cmd.op     = OP_JEND;
        state_next = S_PUSH;
      end
      S_PUSH: begin
        // Load the output register once it is free or being emptied.
        if (!lane_valid || lane_ready) begin
          cmd.op          = OP_PUSH;
          lane_valid_next = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= '0;
      round      <= '0;
      step       <= '0;
      lane_valid <= 1'b0;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      round      <= round_next;
      step       <= step_next;
      lane_valid <= lane_valid_next;
    end
  end

endmodule

[src/xlseed_dp.sv]
// Datapath: configuration, splitmix64 chain, jump accumulators and output register.
module xlseed_dp
  import xlseed_pkg::*;
#(
  parameter int MAX_LANES = DEF_MAX_LANES
)
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [SEED_W-1:0]     cfg_data,
  input  xlseed_cmd_t           cmd,
  output logic                  need_seed,
  output logic [LANE_IDX_W-1:0] lane_index,
  output logic [WORD_W-1:0]     word0,
  output logic [WORD_W-1:0]     word1,
  output logic [WORD_W-1:0]     word2,
  output logic [WORD_W-1:0]     word3,
  output logic                  last
);

  // Lane count clamp: the parameter and the index width both bound it.
  localparam int CLAMP_I = (MAX_LANES < INDEX_LANES) ? MAX_LANES : INDEX_LANES;
  localparam logic [COUNT_W-1:0] CLAMP = COUNT_W'(CLAMP_I);

  logic [SEED_W-1:0]     seed;
  logic [COUNT_W-1:0]    lane_count;
  logic [COUNT_W-1:0]    eff_count;
  logic [COUNT_W-1:0]    last_idx;
  logic [SEED_W-1:0]     z;
  logic [SEED_W-1:0]     acc;
  logic [SEED_W-1:0]     prod;
  logic [SEED_W-1:0]     mul_const;
  logic [WORD_W-1:0]     mul_a, mul_b;
  logic [SEED_W-1:0]     mix_out;
  word_t                 lane_state [4];
  word_t                 jump_accum [4];
  logic [4*WORD_W-1:0]   state_flat;
  logic [4*WORD_W-1:0]   state_adv;
  logic [LANE_IDX_W-1:0] lane_counter;
  logic                  started;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      seed       <= '0;
      lane_count <= COUNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEED:       seed       <= cfg_data;
        REG_LANE_COUNT: lane_count <= cfg_data[COUNT_W-1:0];
        default:        seed       <= seed;
      endcase
    end
  end

  // Effective lane count and the restart condition.
  always_comb begin
    if (lane_count == '0) begin
      eff_count = COUNT_W'(1);
    end else if (lane_count > CLAMP) begin
      eff_count = CLAMP;
    end else begin
      eff_count = lane_count;
    end
  end
  assign last_idx  = eff_count - COUNT_W'(1);
  assign need_seed = !started || ({1'b0, lane_counter} >= last_idx);

  // Shared 32x32 multiplier for the 64-bit splitmix products.
  assign mul_const = cmd.csel ? SM_MUL2 : SM_MUL1;
  always_comb begin
    case (cmd.op)
      OP_MUL1: begin
        mul_a = z[WORD_W-1:0];
        mul_b = mul_const[SEED_W-1:WORD_W];
      end
      OP_MUL2: begin
        mul_a = z[SEED_W-1:WORD_W];
        mul_b = mul_const[WORD_W-1:0];
      end
      default: begin
        mul_a = z[WORD_W-1:0];
        mul_b = mul_const[WORD_W-1:0];
      end
    endcase
  end

  assign mix_out    = z ^ (z >> 31);
  assign state_flat = {lane_state[3], lane_state[2], lane_state[1], lane_state[0]};
  assign state_adv  = xo_advance(state_flat);

  // Splitmix chain register and multiplier product pipeline.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: z <= seed + SM_GAMMA;
      OP_XS30: z <= z ^ (z >> 30);
      OP_XS27: z <= z ^ (z >> 27);
      OP_MUL0: prod <= {32'b0, mul_a} * {32'b0, mul_b};
      OP_MUL1: begin
        acc  <= prod;
        prod <= {32'b0, mul_a} * {32'b0, mul_b};
      end
      OP_MUL2: begin
        acc[SEED_W-1:WORD_W] <= acc[SEED_W-1:WORD_W] + prod[WORD_W-1:0];
        prod <= {32'b0, mul_a} * {32'b0, mul_b};
      end
      OP_MUL3: z <= {acc[SEED_W-1:WORD_W] + prod[WORD_W-1:0], acc[WORD_W-1:0]};
      OP_FIN:  z <= mix_out + SM_GAMMA;
      default: z <= z;
    endcase
  end

  // Lane state and jump accumulators.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_FIN: lane_state[cmd.widx] <= mix_out[WORD_W-1:0];
      OP_JCLR: begin
        for (int i = 0; i < 4; i++) begin
          jump_accum[i] <= '0;
        end
      end
      OP_JSTEP: begin
        for (int i = 0; i < 4; i++) begin
          if (JUMP_POLY[cmd.step]) begin
            jump_accum[i] <= jump_accum[i] ^ lane_state[i];
          end
          lane_state[i] <= state_adv[i*WORD_W +: WORD_W];
        end
      end
      OP_JEND: begin
        for (int i = 0; i < 4; i++) begin
          lane_state[i] <= jump_accum[i];
        end
      end
      default: lane_state[0] <= lane_state[0];
    endcase
  end

  // Lane counter and started flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      lane_counter <= '0;
      started      <= 1'b0;
    end else if (cmd.op == OP_FIN && cmd.widx == 2'd3) begin
      lane_counter <= '0;
      started      <= 1'b1;
    end else if (cmd.op == OP_JEND) begin
      lane_counter <= lane_counter + LANE_IDX_W'(1);
    end
  end

  // Output register, loaded when a finished word moves out.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_PUSH) begin
      lane_index <= lane_counter;
      word0      <= lane_state[0];
      word1      <= lane_state[1];
      word2      <= lane_state[2];
      word3      <= lane_state[3];
      last       <= ({1'b0, lane_counter} == last_idx);
    end
  end

endmodule

[src/xoshiro128pp_lane_seeder.sv]
// Top level of the xoshiro128++ lane seeder: controller plus datapath.
// A restart word, or one that follows the last lane, runs a load step, four splitmix64
// rounds on one shared 32x32 multiplier (xor-shift 30, multiply, xor-shift 27, multiply,
// final mix) and an output step.
// A next-lane word runs a clear step, 128 jump steps, a write-back step and an output step.
// A new word is taken only once the last one has been loaded into the output register.
// Synchronous reset clears the controller, lane counter and seed, and sets the lane count to 1.
module xoshiro128pp_lane_seeder
  import xlseed_pkg::*;
#(
  parameter int MAX_LANES = DEF_MAX_LANES
)
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [SEED_W-1:0]     cfg_data,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  logic                  restart,
  output logic                  lane_valid,
  input  logic                  lane_ready,
  output logic [LANE_IDX_W-1:0] lane_index,
  output logic [WORD_W-1:0]     word0,
  output logic [WORD_W-1:0]     word1,
  output logic [WORD_W-1:0]     word2,
  output logic [WORD_W-1:0]     word3,
  output logic                  last
);

  xlseed_cmd_t cmd;
  logic        need_seed;

  // Sequencer.
  xlseed_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .restart    (restart),
    .lane_valid (lane_valid),
    .lane_ready (lane_ready),
    .need_seed  (need_seed),
    .cmd        (cmd)
  );

  // Arithmetic and storage.
  xlseed_dp #(
    .MAX_LANES (MAX_LANES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .need_seed  (need_seed),
    .lane_index (lane_index),
    .word0      (word0),
    .word1      (word1),
    .word2      (word2),
    .word3      (word3),
    .last       (last)
  );

endmodule

[src/xlseed_chk.sv]
// Port-level checker for the lane seeder, with its bind statement.
module xlseed_chk
  import xlseed_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  req_valid,
  input logic                  req_ready,
  input logic                  lane_valid,
  input logic                  lane_ready,
  input logic [LANE_IDX_W-1:0] lane_index,
  input logic [WORD_W-1:0]     word0
);

  // Reset leaves the block empty, and ready for a word once reset is released.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> (!lane_valid && (rst || req_ready)))
    else $error("seeder not idle after reset");

  // An accepted word keeps the input side closed while it is worked on.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("input accepted again while busy");

  // A result only appears at the end of work, never straight from idle.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(lane_valid) |-> !$past(req_ready))
    else $error("result appeared without work");

  // A stalled result holds its word.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (lane_valid && !lane_ready) |=> (lane_valid && $stable(lane_index) && $stable(word0)))
    else $error("stalled result changed");

endmodule

bind xoshiro128pp_lane_seeder xlseed_chk u_chk (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req_valid),
  .req_ready  (req_ready),
  .lane_valid (lane_valid),
  .lane_ready (lane_ready),
  .lane_index (lane_index),
  .word0      (word0)
);

[dv/tb_xoshiro128pp_lane_seeder.sv]
// Self-checking testbench that predicts each lane start state of the xoshiro128++ seeder.
`timescale 1ns / 1ps

module tb_xoshiro128pp_lane_seeder;
  import xlseed_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 140;

  // Four state words of one lane, word 0 in the low bits.
  typedef struct packed {
    word_t w3;
    word_t w2;
    word_t w1;
    word_t w0;
  } lane_words_t;

  // One expected output word.
  typedef struct packed {
    logic [LANE_IDX_W-1:0] idx;
    lane_words_t           words;
    logic                  last;
  } lane_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = REG_SEED;
  logic [SEED_W-1:0]     cfg_data = '0;
  logic                  req_valid = 1'b0;
  logic                  req_ready;
  logic                  restart = 1'b0;
  logic                  lane_valid;
  logic                  lane_ready = 1'b0;
  logic [LANE_IDX_W-1:0] lane_index;
  logic [WORD_W-1:0]     word0;
  logic [WORD_W-1:0]     word1;
  logic [WORD_W-1:0]     word2;
  logic [WORD_W-1:0]     word3;
  logic                  last;

  // Shadow of the configuration and of the lane generator.
  logic [SEED_W-1:0]     seed_reg = '0;
  logic [COUNT_W-1:0]    count_reg = 1;
  logic [LANE_IDX_W-1:0] cur_lane = '0;
  logic                  seeded = 1'b0;
  lane_words_t           cur_state = '0;

  lane_result_t pending_lanes[$];
  int mismatches = 0;
  int cycles = 0;

  // Idle odds in percent for each side, and the receiver hold-off request.
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_len = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_cnt = 0;

  xoshiro128pp_lane_seeder DUT (.*);

  always #10 clk = ~clk;

  // One splitmix64 round.
  function automatic logic [SEED_W-1:0] splitmix_next(input logic [SEED_W-1:0] x);
    logic [SEED_W-1:0] z;
    z = x + SM_GAMMA;
    z = (z ^ (z >> 30)) * SM_MUL1;
    z = (z ^ (z >> 27)) * SM_MUL2;
    return z ^ (z >> 31);
  endfunction

  // Lane zero: low halves of four chained splitmix64 outputs.
  function automatic lane_words_t seed_lane(input logic [SEED_W-1:0] sd);
    logic [SEED_W-1:0] c;
    lane_words_t s;
    c = splitmix_next(sd);
    s.w0 = c[WORD_W-1:0];
    c = splitmix_next(c);
    s.w1 = c[WORD_W-1:0];
    c = splitmix_next(c);
    s.w2 = c[WORD_W-1:0];
    c = splitmix_next(c);
    s.w3 = c[WORD_W-1:0];
    return s;
  endfunction

  // One xoshiro128 state transition.
  function automatic lane_words_t xo_step(input lane_words_t s);
    word_t t;
    t = s.w1 << 9;
    s.w2 = s.w2 ^ s.w0;
    s.w3 = s.w3 ^ s.w1;
    s.w1 = s.w1 ^ s.w2;
    s.w0 = s.w0 ^ s.w3;
    s.w2 = s.w2 ^ t;
    s.w3 = {s.w3[20:0], s.w3[31:21]};
    return s;
  endfunction

  // The 2^64 jump: accumulate the state at every set polynomial bit.
  function automatic lane_words_t jump64(input lane_words_t s);
    lane_words_t acc;
    int k;
    acc = '0;
    for (k = 0; k < 128; k++) begin
      if (JUMP_POLY[k]) begin
        acc = acc ^ s;
      end
      s = xo_step(s);
    end
    return acc;
  endfunction

  // Advance the shadow generator for one accepted word and queue its lane.
  task automatic predict_lane(input logic rs);
    int lanes;
    lane_result_t r;
    lanes = (count_reg == 0) ? 1 : int'(count_reg);
    if (lanes > DEF_MAX_LANES) lanes = DEF_MAX_LANES;
    if (lanes > INDEX_LANES) lanes = INDEX_LANES;
    if (rs || !seeded || int'(cur_lane) >= lanes - 1) begin
      cur_state = seed_lane(seed_reg);
      cur_lane = '0;
      seeded = 1'b1;
    end else begin
      cur_state = jump64(cur_state);
      cur_lane = cur_lane + 1'b1;
    end
    r.idx = cur_lane;
    r.words = cur_state;
    r.last = (int'(cur_lane) == lanes - 1);
    pending_lanes = {pending_lanes, r};
  endtask

  // Offer one request word, with a random gap first, and wait for acceptance.
  task automatic send_word(input logic rs);
    if ($urandom_range(99) < tx_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    req_valid <= 1'b1;
    restart <= rs;
    do @(posedge clk); while (!req_ready);
    predict_lane(rs);
  endtask

  // Stop offering and wait until every queued lane has come out.
  task automatic drain();
    req_valid <= 1'b0;
    while (pending_lanes.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write one configuration register; the block must be idle.
  task automatic write_reg(input logic idx, input logic [SEED_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_SEED) seed_reg = data;
    else count_reg = data[COUNT_W-1:0];
  endtask

  task automatic check_field(input string name, input logic [WORD_W-1:0] exp_v,
                             input logic [WORD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Receiver: random stalls, or a long hold-off when the test asks for one.
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_cnt <= hold_len;
      lane_ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      lane_ready <= 1'b0;
    end else begin
      lane_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Compare every accepted lane word with the oldest prediction.
  always @(posedge clk) begin
    lane_result_t e;
    if (!rst && lane_valid && lane_ready) begin
      if (pending_lanes.size() == 0) begin
        $error("unexpected lane word: lane_index %0d", lane_index);
        mismatches++;
      end else begin
        e = pending_lanes.pop_front();
        check_field("lane_index", WORD_W'(e.idx), WORD_W'(lane_index));
        check_field("word0", e.words.w0, word0);
        check_field("word1", e.words.w1, word1);
        check_field("word2", e.words.w2, word2);
        check_field("word3", e.words.w3, word3);
        check_field("last", WORD_W'(e.last), WORD_W'(last));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Reset values only: the first word restarts, later ones wrap on one lane.
  task automatic test_reset_defaults();
    send_word(1'b0);
    send_word(1'b0);
    send_word(1'b1);
    drain();
  endtask

  // Seed and lane count at their extremes, including zero and clamped counts.
  task automatic test_config_extremes();
    write_reg(REG_SEED, {SEED_W{1'b1}});
    write_reg(REG_LANE_COUNT, '0);
    send_word(1'b0);
    send_word(1'b0);
    drain();
    write_reg(REG_LANE_COUNT, SEED_W'(1024));
    send_word(1'b1);
    send_word(1'b0);
    send_word(1'b0);
    drain();
    write_reg(REG_SEED, {$urandom, $urandom});
    write_reg(REG_LANE_COUNT, SEED_W'(2047));
    send_word(1'b0);
    send_word(1'b1);
    drain();
    write_reg(REG_LANE_COUNT, SEED_W'(1025));
    send_word(1'b0);
    drain();
    write_reg(REG_SEED, '0);
    write_reg(REG_LANE_COUNT, SEED_W'(2));
    send_word(1'b1);
    send_word(1'b0);
    send_word(1'b0);
    drain();
  endtask

  // Seed changes wait for the next restart; a lowered count forces one.
  task automatic test_midrun_changes();
    write_reg(REG_SEED, {$urandom, $urandom});
    write_reg(REG_LANE_COUNT, SEED_W'(8));
    send_word(1'b1);
    repeat (3) send_word(1'b0);
    drain();
    write_reg(REG_SEED, {$urandom, $urandom});
    send_word(1'b0);
    drain();
    write_reg(REG_LANE_COUNT, SEED_W'(5));
    send_word(1'b0);
    send_word(1'b0);
    send_word(1'b0);
    drain();
    write_reg(REG_LANE_COUNT, SEED_W'(3));
    send_word(1'b0);
    drain();
  endtask

  // Random configurations and mostly next-lane requests with some restarts.
  task automatic test_random_traffic(input int tx, input int rx, input int items);
    int sent;
    int seg;
    int k;
    logic [SEED_W-1:0] d;
    tx_idle_pct = tx;
    rx_idle_pct = rx;
    sent = 0;
    while (sent < items) begin
      write_reg(REG_SEED, {$urandom, $urandom});
      d = {$urandom, $urandom};
      case ($urandom_range(9))
        0: begin
          d[COUNT_W-1:0] = '0;
        end
        1: begin
          d[COUNT_W-1:0] = COUNT_W'($urandom_range(1025, 2047));
        end
        default: begin
          d[COUNT_W-1:0] = COUNT_W'($urandom_range(1, 10));
        end
      endcase
      write_reg(REG_LANE_COUNT, d);
      seg = $urandom_range(6, 16);
      for (k = 0; k < seg; k++) send_word($urandom_range(9) == 0);
      sent += seg;
      drain();
    end
  endtask

  // Long receiver hold-off while requests keep coming, then a full pause.
  task automatic test_backpressure();
    int k;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(REG_LANE_COUNT, SEED_W'(16));
    hold_len <= 500;
    hold_seq <= hold_seq + 1;
    send_word(1'b1);
    for (k = 0; k < 5; k++) send_word(1'b0);
    drain();
  endtask

  // Walk every lane of the largest count, then one more to wrap.
  task automatic test_full_sweep();
    int k;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(REG_SEED, {$urandom, $urandom});
    write_reg(REG_LANE_COUNT, SEED_W'(2047));
    send_word(1'b1);
    for (k = 0; k < INDEX_LANES; k++) send_word(1'b0);
    drain();
  endtask

  initial begin
    tx_idle_pct = 23;
    rx_idle_pct = 67;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_config_extremes();
    test_midrun_changes();
    test_random_traffic(23, 67, 45);
    test_random_traffic(67, 23, 45);
    test_backpressure();
    test_full_sweep();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
src/xlseed_pkg.sv
src/xlseed_ctrl.sv
src/xlseed_dp.sv
src/xoshiro128pp_lane_seeder.sv
src/xlseed_chk.sv
dv/tb_xoshiro128pp_lane_seeder.sv
